// ===== design/assert_macros.svh =====
// Assertion macros shared by the LRU page replacement RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

`define LRU_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

`define LRU_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`define LRU_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define LRU_ASSERT(label, prop, msg)

`define LRU_ASSERT_IMPL(label, ante, cons, msg)

`define LRU_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

// ===== design/lru_pkg.sv =====
// Shared constants and types for the LRU page replacement block.
package lru_pkg;

  localparam int FRAMES     = 4;
  localparam int PAGE_BITS  = 16;
  localparam int FRAME_BITS = $clog2(FRAMES);
  localparam int RANK_BITS  = FRAME_BITS;
  localparam int COUNT_BITS = 32;

  typedef logic [PAGE_BITS-1:0]  page_t;
  typedef logic [FRAME_BITS-1:0] frame_t;
  typedef logic [RANK_BITS-1:0]  rank_t;
  typedef logic [COUNT_BITS-1:0] count_t;

  typedef struct packed {
    page_t page_number;
    logic  end_of_sequence;
  } req_t;

  typedef struct packed {
    logic   hit;
    frame_t frame_index;
    logic   evicted_valid;
    page_t  evicted_page;
    count_t fault_count;
  } rsp_t;

  typedef struct packed {
    logic   hit;
    frame_t hit_idx;
    logic   empty;
    frame_t empty_idx;
    frame_t victim_idx;
    rank_t  victim_rank;
  } scan_t;

endpackage

// ===== design/lru_req_if.sv =====
// Handshake channel that carries one page reference word.
interface lru_req_if;
  import lru_pkg::*;

  logic valid;
  logic ready;
  req_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== design/lru_rsp_if.sv =====
// Handshake channel that carries one replacement result word.
interface lru_rsp_if;
  import lru_pkg::*;

  logic valid;
  logic ready;
  rsp_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== design/lru_scan.sv =====
// Shared compare unit that examines one frame per cycle while step is high and keeps the scan results.
module lru_scan (
  input  logic           clk,
  input  logic           step,
  input  lru_pkg::frame_t idx,
  input  lru_pkg::page_t  page,
  input  lru_pkg::page_t  frame_pg,
  input  logic           frame_vld,
  input  lru_pkg::rank_t  frame_rank,
  output lru_pkg::scan_t  result
);
  import lru_pkg::*;

  scan_t base;
  scan_t result_next;
  logic  match;
  logic  first;

  assign match = frame_vld && (frame_pg == page);
  assign first = (idx == '0);

  always_comb begin
    if (first) begin
      base = '0;
    end else begin
      base = result;
    end
    result_next = base;
    if (match && !base.hit) begin
      result_next.hit     = 1'b1;
      result_next.hit_idx = idx;
    end
    if (!frame_vld && !base.empty) begin
      result_next.empty     = 1'b1;
      result_next.empty_idx = idx;
    end
    if (first || (frame_rank > base.victim_rank)) begin
      result_next.victim_idx  = idx;
      result_next.victim_rank = frame_rank;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      result <= result_next;
    end
  end

endmodule

// ===== design/lru_page_replacement_top.sv =====
// Top level of the LRU page replacement block with its sequencer and frame state.
//
// Each page reference word passes through the accept cycle, a scan in which the
// shared compare unit examines the frames one at a time, and the update cycle that writes
// the frame table and loads the result register. The update cycle waits while a
// previous result word is still held on the output. The frames keep valid bits, and
// valid frames hold distinct recency ranks; a word marked end of sequence clears them
// and the fault count once its result is loaded.
`include "assert_macros.svh"

module lru_page_replacement_top (
  input logic       clk,
  input logic       rst,
  lru_req_if.sink   req,
  lru_rsp_if.source rsp
);
  import lru_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UPDATE
  } state_t;

  state_t            state;
  frame_t            scan_idx;
  req_t              cur;
  page_t             frame_page [FRAMES];
  logic [FRAMES-1:0] frame_valid;
  rank_t             recency_rank [FRAMES];
  count_t            faults_seen;

  scan_t  scan;
  frame_t chosen;
  rank_t  old_rank;
  logic   age_all;
  logic   evict;
  rank_t  rank_next [FRAMES];
  count_t faults_next;
  logic   out_free;
  logic   scan_last;

  lru_scan u_scan (
    .clk        (clk),
    .step       (state == ST_SCAN),
    .idx        (scan_idx),
    .page       (cur.page_number),
    .frame_pg   (frame_page[scan_idx]),
    .frame_vld  (frame_valid[scan_idx]),
    .frame_rank (recency_rank[scan_idx]),
    .result     (scan)
  );

  assign req.ready = (state == ST_IDLE);
  assign out_free  = !rsp.valid || rsp.ready;
  assign scan_last = (scan_idx == FRAME_BITS'(FRAMES - 1));

  always_comb begin
    priority if (scan.hit) begin
      chosen  = scan.hit_idx;
      age_all = 1'b0;
      evict   = 1'b0;
    end else if (scan.empty) begin
      chosen  = scan.empty_idx;
      age_all = 1'b1;
      evict   = 1'b0;
    end else begin
      chosen  = scan.victim_idx;
      age_all = 1'b0;
      evict   = 1'b1;
    end
    old_rank = recency_rank[chosen];
    for (int g = 0; g < FRAMES; g++) begin
      rank_next[g] = recency_rank[g];
      if ((FRAME_BITS'(g) != chosen) && frame_valid[g] &&
          (age_all || (recency_rank[g] < old_rank))) begin
        rank_next[g] = recency_rank[g] + RANK_BITS'(1);
      end
    end
    rank_next[chosen] = '0;
    if (scan.hit || (faults_seen == '1)) begin
      faults_next = faults_seen;
    end else begin
      faults_next = faults_seen + COUNT_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      scan_idx     <= '0;
      frame_valid  <= '0;
      recency_rank <= '{default: '0};
      faults_seen  <= '0;
      rsp.valid    <= 1'b0;
    end else begin
      if (state == ST_UPDATE && out_free) begin
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (req.valid) begin
            cur      <= req.data;
            scan_idx <= '0;
            state    <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          scan_idx <= scan_idx + FRAME_BITS'(1);
          if (scan_last) begin
            state <= ST_UPDATE;
          end
        end
        ST_UPDATE: begin
          if (out_free) begin
            rsp.data.hit           <= scan.hit;
            rsp.data.frame_index   <= chosen;
            rsp.data.evicted_valid <= evict;
            rsp.data.evicted_page  <= evict ? frame_page[chosen] : '0;
            rsp.data.fault_count   <= faults_next;
            frame_page[chosen]     <= cur.page_number;
            if (cur.end_of_sequence) begin
              frame_valid  <= '0;
              recency_rank <= '{default: '0};
              faults_seen  <= '0;
            end else begin
              frame_valid[chosen] <= 1'b1;
              recency_rank        <= rank_next;
              faults_seen         <= faults_next;
            end
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  `LRU_ASSERT_IMPL(a_hit_no_evict, rsp.valid && rsp.data.hit, !rsp.data.evicted_valid, "hit evicted")
  `LRU_ASSERT_NEXT(a_accept, req.valid && req.ready, state == ST_SCAN && scan_idx == '0, "no scan")
  `LRU_ASSERT_IMPL(a_rsp_src, $rose(rsp.valid), $past(state == ST_UPDATE), "result outside update")
  `LRU_ASSERT_IMPL(a_evict_full, state == ST_UPDATE && evict, &frame_valid, "evict with free frame")

endmodule
